// ===== rtl/core/srm_pkg.sv =====
// Shared constants and types for the smoothed rate meter.
package srm_pkg;

	localparam int COUNT_W        = 32;
	localparam int TIME_W         = 48;
	localparam int RATE_W         = 48;
	localparam int RATE_FRAC_BITS = 16;
	localparam int GAIN_W         = 17;
	localparam int GAIN_FRAC      = 16;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	// Shared multiplier: wide operand times narrow operand.
	localparam int MUL_A_W = RATE_W;
	localparam int MUL_B_W = 20;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam logic [MUL_B_W-1:0] US_PER_S = MUL_B_W'(1000000);

	// dv * 1e6 stays below 2^52; scaled by the fraction bits it is the dividend.
	localparam int SCALED_W   = COUNT_W + MUL_B_W;
	localparam int DIV_NUM_W  = SCALED_W + RATE_FRAC_BITS;
	localparam int NUM_HI_W   = DIV_NUM_W - RATE_W;
	localparam int DIV_STEPS  = RATE_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [RATE_W-1:0] quot;
	} div_stat_t;

endpackage

// ===== rtl/core/srm_mul.sv =====
// Shared registered multiplier for the rate scaling and blend step.
module srm_mul (
	input  logic                       clk,
	input  logic [srm_pkg::MUL_A_W-1:0] a,
	input  logic [srm_pkg::MUL_B_W-1:0] b,
	output logic [srm_pkg::PROD_W-1:0]  prod
);
	import srm_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/core/srm_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow detect.
module srm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [srm_pkg::DIV_NUM_W-1:0] num,
	input  logic [srm_pkg::RATE_W-1:0]    den,
	output srm_pkg::div_stat_t            stat
);
	import srm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 ovf_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    quo_q;

	logic                 ovf_now;
	logic [RATE_W:0]      trial;
	logic [RATE_W:0]      diff;
	logic                 q_bit;

	// quotient would not fit in RATE_W bits
	assign ovf_now = {{(RATE_W-NUM_HI_W){1'b0}}, num[DIV_NUM_W-1:RATE_W]} >= den;
	assign trial   = {rem_q, quo_q[RATE_W-1]};
	assign diff    = trial - {1'b0, den};
	assign q_bit   = ~diff[RATE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (ovf_now) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(RATE_W-NUM_HI_W){1'b0}}, num[DIV_NUM_W-1:RATE_W]};
			quo_q <= num[RATE_W-1:0];
			ovf_q <= ovf_now;
		end else if (busy_q) begin
			rem_q <= q_bit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			quo_q <= {quo_q[RATE_W-2:0], q_bit};
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign stat.quot = quo_q;

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != DIV_CNT_W'(DIV_STEPS - 1)) |=> busy_q)
		else $error("divider run ended early");
`endif

endmodule

// ===== rtl/core/smoothed_rate_meter.sv =====
// Smoothed counter rate meter: one sample in, one rate result out per transfer.
// Path: a first, stale or dropping sample goes from ST_CHECK straight to ST_DONE; a rate
// update passes ST_DIVLD, ST_DIVW (48-step divider), ST_DIFF, ST_SCALE and ST_ADD; the
// divider finishes at once when the quotient saturates. The result waits in ST_DONE while stalled.
// Input ready again once the result is registered, so only one sample is in flight at a time.
// Reset: asynchronous, clears history, rate and gain (gain returns to 1.0).
module smoothed_rate_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srm_pkg::GAIN_W-1:0]    cfg_wdata,  // filter_gain
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [79:0]                   s_tdata,    // [31:0] count_value, [79:32] sample_time_us
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [srm_pkg::RATE_W-1:0]    m_tdata,    // [47:0] rate_estimate
	output logic [1:0]                    m_tuser     // [0] sample_taken, [1] rate_saturated
);
	import srm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_DIVLD = 8'b0000_0100,
		ST_DIVW  = 8'b0000_1000,
		ST_DIFF  = 8'b0001_0000,
		ST_SCALE = 8'b0010_0000,
		ST_ADD   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0]  gain_q;
	logic               have_prev_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [COUNT_W-1:0] prev_value_q;
	logic [RATE_W-1:0]  smoothed_q;

	logic [COUNT_W-1:0] cur_q;
	logic [TIME_W-1:0]  now_q;
	logic [RATE_W-1:0]  dt_q;
	logic [RATE_W-1:0]  inst_q;
	logic               sat_q;
	logic               ge_q;
	logic [RATE_W-1:0]  diff_q;

	logic [RATE_W-1:0]  res_rate_q;
	logic               res_taken_q;
	logic               res_sat_q;

	logic               m_tvalid_q;
	logic [RATE_W-1:0]  m_rate_q;
	logic [1:0]         m_flags_q;

	logic [COUNT_W:0]   dv;
	logic [GAIN_W-1:0]  gain_eff;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic               div_start;
	logic [DIV_NUM_W-1:0] div_num;
	div_stat_t          div_st;
	logic [RATE_W-1:0]  step;
	logic [RATE_W-1:0]  rate_new;
	logic               in_xfer;
	logic               out_free;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign dv       = {cur_q[COUNT_W-1], cur_q} - {prev_value_q[COUNT_W-1], prev_value_q};
	assign gain_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

	// multiplier serves the scaling by 1e6 first, the gain step later
	always_comb begin
		if (state_q == ST_CHECK) begin
			mul_a = {{(MUL_A_W-COUNT_W){1'b0}}, dv[COUNT_W-1:0]};
			mul_b = US_PER_S;
		end else begin
			mul_a = diff_q;
			mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_eff};
		end
	end

	srm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign div_start = (state_q == ST_DIVLD);
	assign div_num   = {prod[SCALED_W-1:0], {RATE_FRAC_BITS{1'b0}}};

	srm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dt_q),
		.stat   (div_st)
	);

	assign step     = prod[GAIN_FRAC +: RATE_W];
	assign rate_new = ge_q ? (smoothed_q + step) : (smoothed_q - step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_ONE;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_prev_q  <= 1'b0;
			prev_time_q  <= '0;
			prev_value_q <= '0;
			smoothed_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (have_prev_q && now_q <= prev_time_q) begin
						state_q <= ST_DONE;
					end else if (!have_prev_q || dv[COUNT_W]) begin
						// first sample or counter drop: restart from zero rate
						have_prev_q  <= 1'b1;
						prev_time_q  <= now_q;
						prev_value_q <= cur_q;
						smoothed_q   <= '0;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_DIVLD;
					end
				end
				ST_DIVLD: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_st.done) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ADD;
				ST_ADD: begin
					prev_time_q  <= now_q;
					prev_value_q <= cur_q;
					smoothed_q   <= rate_new;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q <= s_tdata[COUNT_W-1:0];
			now_q <= s_tdata[COUNT_W +: TIME_W];
		end
		if (state_q == ST_CHECK) begin
			dt_q <= now_q - prev_time_q;
			if (have_prev_q && now_q <= prev_time_q) begin
				res_rate_q  <= smoothed_q;
				res_taken_q <= 1'b0;
				res_sat_q   <= 1'b0;
			end else begin
				// zero rate for a first sample or a drop; a rate update overwrites it
				res_rate_q  <= '0;
				res_taken_q <= 1'b1;
				res_sat_q   <= 1'b0;
			end
		end
		if (state_q == ST_DIVW && div_st.done) begin
			inst_q <= div_st.ovf ? RATE_MAX : div_st.quot;
			sat_q  <= div_st.ovf;
		end
		if (state_q == ST_DIFF) begin
			ge_q   <= inst_q >= smoothed_q;
			diff_q <= (inst_q >= smoothed_q) ? (inst_q - smoothed_q) : (smoothed_q - inst_q);
		end
		if (state_q == ST_ADD) begin
			res_rate_q  <= rate_new;
			res_taken_q <= 1'b1;
			res_sat_q   <= sat_q || (rate_new == RATE_MAX);
		end
		if (state_q == ST_DONE && out_free) begin
			m_rate_q  <= res_rate_q;
			m_flags_q <= {res_sat_q, res_taken_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_rate_q;
	assign m_tuser  = m_flags_q;

`ifndef SYNTH
	a_sat_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("saturation flagged on an ignored sample");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid && !m_tready) |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");
	a_history_kept: assert property (@(posedge clk) disable iff (!arst_n)
		have_prev_q |=> have_prev_q)
		else $error("sample history lost");
`endif

endmodule
